[rtl/eorl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eorl_pkg
// Shared constants, codes and structures of the error-ordered reap list.
// ----------------------------------------------------------------------------
package eorl_pkg;

    // Sizing of the list.
    localparam int DEPTH          = 256;
    localparam int ID_BITS        = 16;
    localparam int ERR_BITS       = 16;
    localparam int CNT_BITS       = $clog2(DEPTH + 1);
    localparam int COUNT_OUT_BITS = 9;
    localparam int SCAN_LEVELS    = $clog2(DEPTH);

    // Request modes.
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_UP     = 2'd2,
        MODE_DOWN   = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_DUP    = 2'd2,
        STAT_ABSENT = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MATCH = 2'd1,
        ST_APPLY = 2'd2
    } state_t;

    // Contents of one cell.
    typedef struct packed {
        logic                valid;
        logic [ID_BITS-1:0]  id;
        logic [ERR_BITS-1:0] err;
    } cell_state_t;

    // What a cell sees of a neighbor.
    typedef struct packed {
        logic                valid;
        logic                match;
        logic [ID_BITS-1:0]  id;
        logic [ERR_BITS-1:0] err;
    } nbr_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                capture;
        logic                apply;
        logic                do_add;
        mode_t               mode;
        logic [ID_BITS-1:0]  id;
        logic [ERR_BITS-1:0] err;
    } cmd_t;

endpackage

[rtl/eorl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eorl_cell
// One list slot: holds an id and error count and trades them with neighbors.
// ----------------------------------------------------------------------------
module eorl_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eorl_pkg::cmd_t       cmd,
    input  eorl_pkg::nbr_t       prev,
    input  eorl_pkg::nbr_t       next,
    input  logic                 tail_ok,
    input  logic                 after,
    output eorl_pkg::cell_state_t cur,
    output eorl_pkg::cell_state_t nxt,
    output logic                 match,
    output logic                 swap
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [eorl_pkg::ID_BITS-1:0]  id_reg;
    logic [eorl_pkg::ID_BITS-1:0]  id_next;
    logic [eorl_pkg::ERR_BITS-1:0] err_reg;
    logic [eorl_pkg::ERR_BITS-1:0] err_next;
    logic                          match_reg;
    logic                          match_next;
    logic                          up_swap;
    logic                          down_swap;

    // Swap conditions as seen from the matching cell.
    assign up_swap   = prev.valid && (cmd.err >= prev.err);
    assign down_swap = next.valid && (cmd.err < next.err);

    // Compare against the request id in the match cycle.
    always_comb
    begin
        match_next = match_reg;
        if (cmd.capture)
        begin
            match_next = valid_reg && (id_reg == cmd.id);
        end
    end

    // Slot update in the apply cycle.
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        err_next   = err_reg;
        if (cmd.apply)
        begin
            case (cmd.mode)
                eorl_pkg::MODE_ADD:
                begin
                    if (cmd.do_add && tail_ok && !valid_reg)
                    begin
                        valid_next = 1'b1;
                        id_next    = cmd.id;
                        err_next   = cmd.err;
                    end
                end
                eorl_pkg::MODE_REMOVE:
                begin
                    // Every slot at or behind the removed one closes up.
                    if (after)
                    begin
                        valid_next = next.valid;
                        id_next    = next.id;
                        err_next   = next.err;
                    end
                end
                eorl_pkg::MODE_UP:
                begin
                    if (match_reg)
                    begin
                        if (up_swap)
                        begin
                            id_next  = prev.id;
                            err_next = prev.err;
                        end
                        else
                        begin
                            err_next = cmd.err;
                        end
                    end
                    else if (next.match && (cmd.err >= err_reg))
                    begin
                        id_next  = cmd.id;
                        err_next = cmd.err;
                    end
                end
                eorl_pkg::MODE_DOWN:
                begin
                    if (match_reg)
                    begin
                        if (down_swap)
                        begin
                            id_next  = next.id;
                            err_next = next.err;
                        end
                        else
                        begin
                            err_next = cmd.err;
                        end
                    end
                    else if (prev.match && (cmd.err < err_reg))
                    begin
                        id_next  = cmd.id;
                        err_next = cmd.err;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        err_reg <= err_next;
    end

    assign cur   = '{valid: valid_reg, id: id_reg, err: err_reg};
    assign nxt   = '{valid: valid_next, id: id_next, err: err_next};
    assign match = match_reg;
    assign swap  = match_reg &&
                   (((cmd.mode == eorl_pkg::MODE_UP) && up_swap) ||
                    ((cmd.mode == eorl_pkg::MODE_DOWN) && down_swap));

endmodule

[rtl/eorl_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eorl_scan
// Prefix OR of the cell match flags and the found and moved summaries.
// ----------------------------------------------------------------------------
module eorl_scan (
    input  logic [eorl_pkg::DEPTH-1:0] match_vec,
    input  logic [eorl_pkg::DEPTH-1:0] swap_vec,
    output logic [eorl_pkg::DEPTH-1:0] after_vec,
    output logic                       found,
    output logic                       moved
);

    logic [eorl_pkg::DEPTH-1:0] lvl [eorl_pkg::SCAN_LEVELS+1];

    // Log-depth prefix OR: bit i is set when some slot at or before i matched.
    always_comb
    begin
        lvl[0] = match_vec;
        for (int l = 0; l < eorl_pkg::SCAN_LEVELS; l++)
        begin
            for (int i = 0; i < eorl_pkg::DEPTH; i++)
            begin
                if (i >= (1 << l))
                begin
                    lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
                end
                else
                begin
                    lvl[l+1][i] = lvl[l][i];
                end
            end
        end
    end

    assign after_vec = lvl[eorl_pkg::SCAN_LEVELS];
    assign found     = lvl[eorl_pkg::SCAN_LEVELS][eorl_pkg::DEPTH-1];
    assign moved     = |swap_vec;

endmodule

[rtl/error_ordered_reap_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// error_ordered_reap_list
// Ordered list of ids with error counts, kept in a row of slot cells.
// ----------------------------------------------------------------------------
// A request passes through the match and apply states and its result is
// registered in the apply cycle; every cell compares its id in the match
// cycle and updates from its neighbors in the apply cycle. The next request
// is taken during the apply cycle of the current one, once the result register is free.
// Reset empties the list and clears the result valid flag at once.
module error_ordered_reap_list (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          mode,
    input  logic [eorl_pkg::ID_BITS-1:0]        entity_id,
    input  logic [eorl_pkg::ERR_BITS-1:0]       error_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic                                moved,
    output logic                                head_valid,
    output logic [eorl_pkg::ID_BITS-1:0]        head_id,
    output logic [eorl_pkg::COUNT_OUT_BITS-1:0] entry_count
);

    eorl_pkg::state_t                     state_reg;
    eorl_pkg::state_t                     state_next;
    eorl_pkg::mode_t                      mode_reg;
    logic [eorl_pkg::ID_BITS-1:0]         id_reg;
    logic [eorl_pkg::ERR_BITS-1:0]        err_reg;
    logic [eorl_pkg::CNT_BITS-1:0]        cnt_reg;
    logic [eorl_pkg::CNT_BITS-1:0]        cnt_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [1:0]                           status_reg;
    logic [1:0]                           status_next;
    logic                                 moved_reg;
    logic                                 head_valid_reg;
    logic [eorl_pkg::ID_BITS-1:0]         head_id_reg;
    logic [eorl_pkg::ID_BITS-1:0]         head_id_next;
    logic [eorl_pkg::CNT_BITS+eorl_pkg::COUNT_OUT_BITS-1:0] cnt_wide;

    logic                                 accept;
    logic                                 out_free;
    logic                                 capture;
    logic                                 apply;
    logic                                 found;
    logic                                 any_moved;
    logic                                 full;
    logic                                 do_add;
    eorl_pkg::cmd_t                       cmd;

    eorl_pkg::cell_state_t                cur  [eorl_pkg::DEPTH];
    eorl_pkg::cell_state_t                nxt  [eorl_pkg::DEPTH];
    logic [eorl_pkg::DEPTH-1:0]           match_vec;
    logic [eorl_pkg::DEPTH-1:0]           swap_vec;
    logic [eorl_pkg::DEPTH-1:0]           after_vec;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eorl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = eorl_pkg::ST_MATCH;
                end
            end
            eorl_pkg::ST_MATCH:
            begin
                state_next = eorl_pkg::ST_APPLY;
            end
            eorl_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = accept ? eorl_pkg::ST_MATCH : eorl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eorl_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        capture  = 1'b0;
        apply    = 1'b0;
        in_stall = 1'b1;
        case (state_reg)
            eorl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            eorl_pkg::ST_MATCH:
            begin
                capture = 1'b1;
            end
            eorl_pkg::ST_APPLY:
            begin
                apply    = out_free;
                in_stall = !out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Request decisions taken in the apply cycle.
    assign full   = cur[eorl_pkg::DEPTH-1].valid;
    assign do_add = !found && !full;

    assign cmd = '{capture: capture, apply: apply, do_add: do_add,
                   mode: mode_reg, id: id_reg, err: err_reg};

    // Row of slot cells.
    for (genvar g = 0; g < eorl_pkg::DEPTH; g++)
    begin : g_cell
        eorl_pkg::nbr_t prev_n;
        eorl_pkg::nbr_t next_n;
        logic           tail_ok;

        if (g == 0)
        begin : g_first
            assign prev_n  = '0;
            assign tail_ok = 1'b1;
        end
        else
        begin : g_mid
            assign prev_n  = '{valid: cur[g-1].valid, match: match_vec[g-1],
                               id: cur[g-1].id, err: cur[g-1].err};
            assign tail_ok = cur[g-1].valid;
        end

        if (g == eorl_pkg::DEPTH - 1)
        begin : g_last
            assign next_n = '0;
        end
        else
        begin : g_inner
            assign next_n = '{valid: cur[g+1].valid, match: match_vec[g+1],
                              id: cur[g+1].id, err: cur[g+1].err};
        end

        eorl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .prev    (prev_n),
            .next    (next_n),
            .tail_ok (tail_ok),
            .after   (after_vec[g]),
            .cur     (cur[g]),
            .nxt     (nxt[g]),
            .match   (match_vec[g]),
            .swap    (swap_vec[g])
        );
    end

    eorl_scan u_scan (
        .match_vec (match_vec),
        .swap_vec  (swap_vec),
        .after_vec (after_vec),
        .found     (found),
        .moved     (any_moved)
    );

    // Entry count and status of the request being applied.
    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = eorl_pkg::STAT_OK;
        case (mode_reg)
            eorl_pkg::MODE_ADD:
            begin
                if (found)
                begin
                    status_next = eorl_pkg::STAT_DUP;
                end
                else if (full)
                begin
                    status_next = eorl_pkg::STAT_FULL;
                end
                else if (apply)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            eorl_pkg::MODE_REMOVE:
            begin
                if (!found)
                begin
                    status_next = eorl_pkg::STAT_ABSENT;
                end
                else if (apply)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                if (!found)
                begin
                    status_next = eorl_pkg::STAT_ABSENT;
                end
            end
        endcase
    end

    // Head id is reported as zero for an empty list.
    assign head_id_next   = nxt[0].valid ? nxt[0].id : '0;
    assign out_valid_next = apply || (out_valid_reg && out_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eorl_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= eorl_pkg::mode_t'(mode);
            id_reg   <= entity_id;
            err_reg  <= error_count;
        end
        if (apply)
        begin
            status_reg     <= status_next;
            moved_reg      <= any_moved;
            head_valid_reg <= nxt[0].valid;
            head_id_reg    <= head_id_next;
        end
    end

    assign cnt_wide    = {{eorl_pkg::COUNT_OUT_BITS{1'b0}}, cnt_reg};
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign moved       = moved_reg;
    assign head_valid  = head_valid_reg;
    assign head_id     = head_id_reg;
    assign entry_count = cnt_wide[eorl_pkg::COUNT_OUT_BITS-1:0];

endmodule
